// ===== sv/i2cm_pkg.sv =====
package i2cm_pkg;

    // Command codes as they arrive in the kind field.
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_WAIT  = 3'd5;

    // Configuration register indexes.
    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 16;
    localparam logic [1:0]  CFG_HALF   = 2'd0;
    localparam logic [1:0]  CFG_ACK_TO = 2'd1;

    localparam logic [15:0] HALF_RESET   = 16'd50;
    localparam logic [7:0]  ACK_TO_RESET = 8'd250;

    // Depth of the queue between the command front and the pin engine.
    localparam int FRONT_DEPTH_DEF = 2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_sample;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_driving;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_failed;
    } t_res;

    // A classified tick as it waits for the engine.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_sample;
    } t_tick;

endpackage

// ===== sv/i2cm_front.sv =====
module i2cm_front
    import i2cm_pkg::*;
#(
    parameter int DEPTH = FRONT_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_take,
    output t_tick o_tick
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_tick             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_acc, w_pop;
    t_tick             w_tick;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_acc   = i_push && !o_full;
    assign w_pop   = i_take && o_valid;
    assign o_tick  = r_mem[r_rp];

    // Unused kind codes are turned into an empty tick here.
    always_comb begin
        w_tick.write_byte = i_item.write_byte;
        w_tick.send_ack   = i_item.send_ack;
        w_tick.sda_sample = i_item.sda_sample;
        unique case (i_item.kind) inside
            CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_WAIT: w_tick.cmd = i_item.kind;
            default: w_tick.cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[r_wp] <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_acc) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (w_acc && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_acc) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("front queue count beyond depth");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_take) |=> o_full)
        else $error("front queue lost an entry while full");

endmodule

// ===== sv/i2cm_engine.sv =====
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_take,
    input  t_tick                 i_tick,
    output logic                  o_empty,
    input  logic                  i_pop,
    output t_res                  o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_SP_A    = 4'd3;
    localparam logic [3:0] PH_SP_B    = 4'd4;
    localparam logic [3:0] PH_WR_LO   = 4'd5;
    localparam logic [3:0] PH_WR_HI   = 4'd6;
    localparam logic [3:0] PH_RD_LO   = 4'd7;
    localparam logic [3:0] PH_RD_HI   = 4'd8;
    localparam logic [3:0] PH_AK_LO   = 4'd9;
    localparam logic [3:0] PH_AK_HI   = 4'd10;
    localparam logic [3:0] PH_WA_LO   = 4'd11;
    localparam logic [3:0] PH_WA_HI   = 4'd12;
    localparam logic [3:0] PH_WA_POLL = 4'd13;

    logic [15:0] r_half;
    logic [7:0]  r_ack_to;

    logic [3:0]  r_phase, n_phase, w_phase;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_tick, n_tick;
    logic [7:0]  r_wait, n_wait;
    logic        r_ack_choice, n_ack_choice;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_sda_en, n_sda_en;
    logic        r_fail, n_fail;
    logic [7:0]  r_last, n_last;
    logic        n_done;

    logic [15:0] w_limit;
    logic [16:0] w_tick_inc;
    logic        w_half_end;
    logic [15:0] w_tick_run;
    logic [3:0]  w_bit_inc;
    t_res        w_res;

    t_res        r_obuf [2];
    logic        r_owp, r_orp;
    logic [1:0]  r_ocnt;
    logic        w_opop;

    assign o_take  = i_valid && (r_ocnt != 2'd2);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_obuf[r_orp];
    assign w_opop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half   <= HALF_RESET;
            r_ack_to <= ACK_TO_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_HALF) begin
                r_half <= i_cfg_data[15:0];
            end else if (i_cfg_idx == CFG_ACK_TO) begin
                r_ack_to <= i_cfg_data[7:0];
            end
        end
    end

    // A zero half period runs as one tick.
    assign w_limit    = (r_half == 16'd0) ? 16'd1 : r_half;
    assign w_tick_inc = {1'b0, r_tick} + 17'd1;
    assign w_half_end = (w_tick_inc >= {1'b0, w_limit});
    assign w_tick_run = w_half_end ? 16'd0 : w_tick_inc[15:0];
    assign w_bit_inc  = r_bit + 4'd1;
    assign w_phase    = (r_phase > PH_WA_POLL) ? PH_IDLE : r_phase;

    always_comb begin
        n_phase      = w_phase;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_tick       = r_tick;
        n_wait       = r_wait;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_sda_en     = r_sda_en;
        n_fail       = r_fail;
        n_last       = r_last;
        n_done       = 1'b0;
        unique case (w_phase)
            PH_IDLE: begin
                unique case (i_tick.cmd)
                    CMD_START: begin
                        n_sda_en = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                        n_phase  = PH_ST_A; n_tick = '0;
                    end
                    CMD_STOP: begin
                        n_sda_en = 1'b1; n_sda = 1'b0; n_scl = 1'b0;
                        n_phase  = PH_SP_A; n_tick = '0;
                    end
                    CMD_WRITE: begin
                        n_shift  = i_tick.write_byte;
                        n_bit    = '0;
                        n_sda_en = 1'b1; n_scl = 1'b0;
                        n_sda    = i_tick.write_byte[7];
                        n_phase  = PH_WR_LO; n_tick = '0;
                    end
                    CMD_READ: begin
                        n_shift      = '0;
                        n_bit        = '0;
                        n_ack_choice = i_tick.send_ack;
                        n_sda_en     = 1'b0; n_scl = 1'b0;
                        n_phase      = PH_RD_LO; n_tick = '0;
                    end
                    CMD_WAIT: begin
                        n_fail   = 1'b0;
                        n_wait   = '0;
                        n_sda_en = 1'b0; n_sda = 1'b1;
                        n_phase  = PH_WA_LO; n_tick = '0;
                    end
                    default: ;
                endcase
            end
            PH_ST_A: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_sda = 1'b0; n_phase = PH_ST_B;
                end
            end
            PH_ST_B: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
                end
            end
            PH_SP_A: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_scl = 1'b1; n_sda = 1'b1; n_phase = PH_SP_B;
                end
            end
            PH_SP_B: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_phase = PH_IDLE; n_done = 1'b1;
                end
            end
            PH_WR_LO: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_scl = 1'b1; n_phase = PH_WR_HI;
                end
            end
            PH_WR_HI: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_scl   = 1'b0;
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = w_bit_inc;
                    if (w_bit_inc >= 4'd8) begin
                        n_phase = PH_IDLE; n_done = 1'b1;
                    end else begin
                        n_sda   = r_shift[6];
                        n_phase = PH_WR_LO;
                    end
                end
            end
            PH_RD_LO: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_scl = 1'b1; n_phase = PH_RD_HI;
                end
            end
            PH_RD_HI: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_shift = {r_shift[6:0], i_tick.sda_sample};
                    n_bit   = w_bit_inc;
                    n_scl   = 1'b0;
                    if (w_bit_inc >= 4'd8) begin
                        n_sda_en = 1'b1;
                        n_sda    = !r_ack_choice;
                        n_phase  = PH_AK_LO;
                    end else begin
                        n_phase = PH_RD_LO;
                    end
                end
            end
            PH_AK_LO: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_scl = 1'b1; n_phase = PH_AK_HI;
                end
            end
            PH_AK_HI: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_scl   = 1'b0;
                    n_last  = r_shift;
                    n_phase = PH_IDLE; n_done = 1'b1;
                end
            end
            PH_WA_LO: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_scl = 1'b1; n_phase = PH_WA_HI;
                end
            end
            PH_WA_HI: begin
                n_tick = w_tick_run;
                if (w_half_end) begin
                    n_phase = PH_WA_POLL;
                end
            end
            PH_WA_POLL: begin
                if (!i_tick.sda_sample) begin
                    n_scl   = 1'b0;
                    n_fail  = 1'b0;
                    n_phase = PH_IDLE; n_tick = '0; n_done = 1'b1;
                end else if ({1'b0, r_wait} + 9'd1 > {1'b0, r_ack_to}) begin
                    // No acknowledge in time: release the bus through a stop.
                    n_fail   = 1'b1;
                    n_sda_en = 1'b1; n_sda = 1'b0; n_scl = 1'b0;
                    n_phase  = PH_SP_A; n_tick = '0;
                end else begin
                    n_wait = r_wait + 8'd1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        w_res.scl_level   = n_scl;
        w_res.sda_level   = n_sda;
        w_res.sda_driving = n_sda_en;
        w_res.busy_res    = (n_phase != PH_IDLE);
        w_res.done_res    = n_done;
        w_res.read_byte   = n_last;
        w_res.ack_failed  = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit        <= '0;
            r_shift      <= '0;
            r_tick       <= '0;
            r_wait       <= '0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_sda_en     <= 1'b1;
            r_fail       <= 1'b0;
            r_last       <= '0;
        end else if (o_take) begin
            r_phase      <= n_phase;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_tick       <= n_tick;
            r_wait       <= n_wait;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_sda_en     <= n_sda_en;
            r_fail       <= n_fail;
            r_last       <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_obuf[r_owp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (o_take) begin
                r_owp <= !r_owp;
            end
            if (w_opop) begin
                r_orp <= !r_orp;
            end
            if (o_take && !w_opop) begin
                r_ocnt <= r_ocnt + 2'd1;
            end else if (w_opop && !o_take) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && n_done) |-> !w_res.busy_res)
        else $error("command finished while still busy");

    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2)
        else $error("result buffer overfilled");

    a_bit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= 4'd8)
        else $error("bit counter ran past one byte");

endmodule

// ===== sv/i2c_master_bit_engine.sv =====
// Channel    | Handshake        | Beat
// -----------+------------------+--------------------------------------------
// tick in    | push / full      | i_item: kind, write_byte, send_ack, sda_sample
// result out | empty / pop      | o_res: pins, busy, done, read_byte, ack_failed
// config     | i_cfg_we         | i_cfg_idx, i_cfg_data (0 half period, 1 timeout)
//
// One tick beat is taken per cycle while full is low; each produces one result beat.
// A beat is registered in the front queue until the engine takes it, which it does only
// while the result buffer has room; its result is then registered there to be popped.
// Reset is synchronous; both queues come up empty, pins at bus idle.
// A stall on pop backs up through the result buffer and the front queue
// into full; a pause on push only empties the queues.
module i2c_master_bit_engine
    import i2cm_pkg::*;
#(
    parameter int FRONT_DEPTH = FRONT_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_item                 i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_res                  o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic  w_valid;
    logic  w_take;
    t_tick w_tick;

    i2cm_front #(
        .DEPTH (FRONT_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_valid (w_valid),
        .i_take  (w_take),
        .o_tick  (w_tick)
    );

    i2cm_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .o_take     (w_take),
        .i_tick     (w_tick),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int ITEMS_PER_PHASE = 32;

    // Kind values outside the command set; the engine treats them as no command.
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_START_HOLD = 4'd1;
    localparam logic [3:0] S_START_LOW  = 4'd2;
    localparam logic [3:0] S_STOP_LOW   = 4'd3;
    localparam logic [3:0] S_STOP_HIGH  = 4'd4;
    localparam logic [3:0] S_TX_LOW     = 4'd5;
    localparam logic [3:0] S_TX_HIGH    = 4'd6;
    localparam logic [3:0] S_RX_LOW     = 4'd7;
    localparam logic [3:0] S_RX_HIGH    = 4'd8;
    localparam logic [3:0] S_ACK_LOW    = 4'd9;
    localparam logic [3:0] S_ACK_HIGH   = 4'd10;
    localparam logic [3:0] S_WAIT_LOW   = 4'd11;
    localparam logic [3:0] S_WAIT_HIGH  = 4'd12;
    localparam logic [3:0] S_POLL       = 4'd13;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_item                 i_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_res                  o_res;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    i2c_master_bit_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    t_item tick_queue[$];
    t_res  res_due[$];
    bit    beat_taken = 1'b0;
    int    err_count = 0;
    int    cycle_cnt = 0;
    int    items_sent = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;

    // Engine state as predicted from the accepted ticks.
    logic [15:0] cfg_half = HALF_RESET;
    logic [7:0]  cfg_timeout = ACK_TO_RESET;
    logic [3:0]  eng_phase = S_IDLE;
    logic [3:0]  bit_cnt = '0;
    logic [7:0]  shreg = '0;
    logic [15:0] tick_cnt = '0;
    logic [7:0]  poll_cnt = '0;
    logic        ack_sel = 1'b0;
    logic        scl_q = 1'b1;
    logic        sda_q = 1'b1;
    logic        sda_oe = 1'b1;
    logic        failed = 1'b0;
    logic [7:0]  rx_byte = '0;

    function automatic bit half_done();
        logic [16:0] limit;
        limit = (cfg_half == 16'd0) ? 17'd1 : {1'b0, cfg_half};
        if ({1'b0, tick_cnt} + 17'd1 >= limit) begin
            tick_cnt = '0;
            return 1'b1;
        end
        tick_cnt = tick_cnt + 16'd1;
        return 1'b0;
    endfunction

    function automatic void enter_phase(input logic [3:0] nxt);
        eng_phase = nxt;
        tick_cnt = '0;
    endfunction

    task automatic step_engine(input t_item it);
        t_res r;
        logic fin;
        fin = 1'b0;
        unique case (eng_phase)
            S_IDLE: begin
                unique case (it.kind)
                    CMD_START: begin
                        sda_oe = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
                        enter_phase(S_START_HOLD);
                    end
                    CMD_STOP: begin
                        sda_oe = 1'b1; sda_q = 1'b0; scl_q = 1'b0;
                        enter_phase(S_STOP_LOW);
                    end
                    CMD_WRITE: begin
                        shreg = it.write_byte;
                        bit_cnt = '0;
                        sda_oe = 1'b1; scl_q = 1'b0;
                        sda_q = shreg[7];
                        enter_phase(S_TX_LOW);
                    end
                    CMD_READ: begin
                        shreg = '0;
                        bit_cnt = '0;
                        ack_sel = it.send_ack;
                        sda_oe = 1'b0; scl_q = 1'b0;
                        enter_phase(S_RX_LOW);
                    end
                    CMD_WAIT: begin
                        failed = 1'b0;
                        poll_cnt = '0;
                        sda_oe = 1'b0; sda_q = 1'b1;
                        enter_phase(S_WAIT_LOW);
                    end
                    default: ;
                endcase
            end
            S_START_HOLD: if (half_done()) begin
                sda_q = 1'b0;
                enter_phase(S_START_LOW);
            end
            S_START_LOW: if (half_done()) begin
                scl_q = 1'b0;
                enter_phase(S_IDLE);
                fin = 1'b1;
            end
            S_STOP_LOW: if (half_done()) begin
                scl_q = 1'b1; sda_q = 1'b1;
                enter_phase(S_STOP_HIGH);
            end
            S_STOP_HIGH: if (half_done()) begin
                enter_phase(S_IDLE);
                fin = 1'b1;
            end
            S_TX_LOW: if (half_done()) begin
                scl_q = 1'b1;
                enter_phase(S_TX_HIGH);
            end
            S_TX_HIGH: if (half_done()) begin
                scl_q = 1'b0;
                shreg = {shreg[6:0], 1'b0};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) begin
                    enter_phase(S_IDLE);
                    fin = 1'b1;
                end else begin
                    sda_q = shreg[7];
                    enter_phase(S_TX_LOW);
                end
            end
            S_RX_LOW: if (half_done()) begin
                scl_q = 1'b1;
                enter_phase(S_RX_HIGH);
            end
            S_RX_HIGH: if (half_done()) begin
                shreg = {shreg[6:0], it.sda_sample};
                bit_cnt = bit_cnt + 4'd1;
                scl_q = 1'b0;
                if (bit_cnt >= 4'd8) begin
                    sda_oe = 1'b1;
                    sda_q = ~ack_sel;
                    enter_phase(S_ACK_LOW);
                end else begin
                    enter_phase(S_RX_LOW);
                end
            end
            S_ACK_LOW: if (half_done()) begin
                scl_q = 1'b1;
                enter_phase(S_ACK_HIGH);
            end
            S_ACK_HIGH: if (half_done()) begin
                scl_q = 1'b0;
                rx_byte = shreg;
                enter_phase(S_IDLE);
                fin = 1'b1;
            end
            S_WAIT_LOW: if (half_done()) begin
                scl_q = 1'b1;
                enter_phase(S_WAIT_HIGH);
            end
            S_WAIT_HIGH: if (half_done()) begin
                enter_phase(S_POLL);
            end
            S_POLL: begin
                if (!it.sda_sample) begin
                    scl_q = 1'b0;
                    failed = 1'b0;
                    enter_phase(S_IDLE);
                    fin = 1'b1;
                end else if ({1'b0, poll_cnt} + 9'd1 > {1'b0, cfg_timeout}) begin
                    // The slave never answered: close the bus with a stop.
                    failed = 1'b1;
                    sda_oe = 1'b1; sda_q = 1'b0; scl_q = 1'b0;
                    enter_phase(S_STOP_LOW);
                end else begin
                    poll_cnt = poll_cnt + 8'd1;
                end
            end
            default: ;
        endcase
        r.scl_level   = scl_q;
        r.sda_level   = sda_q;
        r.sda_driving = sda_oe;
        r.busy_res    = (eng_phase != S_IDLE);
        r.done_res    = fin;
        r.read_byte   = rx_byte;
        r.ack_failed  = failed;
        res_due.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0h got %0h", name, want, got);
            err_count++;
        end
    endfunction

    // Input side: a new beat is offered at the falling edge once the last one is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || beat_taken) begin
            if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_item <= tick_queue.pop_front();
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_res want;
        beat_taken = push && !full;
        if (beat_taken) begin
            step_engine(i_item);
        end
        if (pop && !empty) begin
            if (res_due.size() == 0) begin
                $error("result beat with nothing expected");
                err_count++;
            end else begin
                want = res_due.pop_front();
                check_field("scl_level", 8'(want.scl_level), 8'(o_res.scl_level));
                check_field("sda_level", 8'(want.sda_level), 8'(o_res.sda_level));
                check_field("sda_driving", 8'(want.sda_driving), 8'(o_res.sda_driving));
                check_field("busy_res", 8'(want.busy_res), 8'(o_res.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(o_res.done_res));
                check_field("read_byte", want.read_byte, o_res.read_byte);
                check_field("ack_failed", 8'(want.ack_failed), 8'(o_res.ack_failed));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [2:0] idle_kind();
        case ($urandom_range(3))
            0: return KIND_SPARE6;
            1: return KIND_SPARE7;
            default: return CMD_NONE;
        endcase
    endfunction

    function automatic logic [2:0] busy_kind(input bit noisy);
        if (noisy && $urandom_range(3) == 0) return 3'($urandom_range(7));
        return CMD_NONE;
    endfunction

    task automatic add_tick(input logic [2:0] kind, input logic sda);
        t_item beat;
        beat.kind       = kind;
        beat.write_byte = 8'($urandom_range(255));
        beat.send_ack   = 1'($urandom_range(1));
        beat.sda_sample = sda;
        tick_queue.push_back(beat);
        items_sent++;
    endtask

    task automatic fill_ticks(input int n, input bit noisy, input bit sda_high);
        for (int i = 0; i < n; i++) begin
            add_tick(busy_kind(noisy), sda_high ? 1'b1 : 1'($urandom_range(1)));
        end
    endtask

    // One command and exactly the ticks it stays busy, then up to two idle ticks.
    task automatic send_command(input logic [2:0] cmd, input logic [7:0] data,
                                input logic ack_lvl, input bit slave_acks);
        t_item beat;
        int hh;
        int polls;
        hh = (cfg_half == 16'd0) ? 1 : int'(cfg_half);
        beat.kind       = cmd;
        beat.write_byte = data;
        beat.send_ack   = ack_lvl;
        beat.sda_sample = 1'($urandom_range(1));
        tick_queue.push_back(beat);
        items_sent++;
        case (cmd)
            CMD_START, CMD_STOP: fill_ticks(2 * hh, 1'b1, 1'b0);
            CMD_WRITE: fill_ticks(16 * hh, 1'b1, 1'b0);
            CMD_READ: fill_ticks(18 * hh, 1'b1, 1'b0);
            CMD_WAIT: begin
                fill_ticks(2 * hh, 1'b1, 1'b0);
                if (slave_acks) begin
                    polls = $urandom_range(int'(cfg_timeout) < 5 ? int'(cfg_timeout) : 5, 0);
                    fill_ticks(polls, 1'b1, 1'b1);
                    add_tick(busy_kind(1'b1), 1'b0);
                end else begin
                    fill_ticks(int'(cfg_timeout) + 1, 1'b1, 1'b1);
                    fill_ticks(2 * hh, 1'b1, 1'b0);
                end
            end
            default: ;
        endcase
        repeat ($urandom_range(2)) add_tick(idle_kind(), 1'($urandom_range(1)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_HALF) begin
            cfg_half = data;
        end else if (idx == CFG_ACK_TO) begin
            cfg_timeout = data[7:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (tick_queue.size() != 0 || push || res_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_transaction();
        send_command(CMD_START, 8'h00, 1'b0, 1'b0);
        send_command(CMD_WRITE, 8'($urandom_range(255)), 1'b0, 1'b0);
        send_command(CMD_WAIT, 8'h00, 1'b0, $urandom_range(3) != 0);
        repeat ($urandom_range(2)) begin
            if ($urandom_range(1)) begin
                send_command(CMD_WRITE, 8'($urandom_range(255)), 1'b0, 1'b0);
                send_command(CMD_WAIT, 8'h00, 1'b0, $urandom_range(3) != 0);
            end else begin
                send_command(CMD_READ, 8'h00, 1'($urandom_range(1)), 1'b0);
            end
        end
        send_command(CMD_STOP, 8'h00, 1'b0, 1'b0);
    endtask

    initial begin
        int pick;
        int phase_base;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing: a start condition at the default half period, then both spare kind codes.
        send_command(CMD_START, 8'h00, 1'b0, 1'b0);
        send_command(KIND_SPARE6, 8'hFF, 1'b1, 1'b0);
        send_command(KIND_SPARE7, 8'h00, 1'b0, 1'b0);
        settle();

        // A zero half period runs as one tick, a zero timeout fails on the first high poll.
        write_reg(CFG_HALF, 16'd0);
        write_reg(CFG_ACK_TO, 16'd0);
        send_command(CMD_WRITE, 8'h00, 1'b0, 1'b0);
        send_command(CMD_WRITE, 8'hFF, 1'b0, 1'b0);
        send_command(CMD_WAIT, 8'h00, 1'b0, 1'b0);
        send_command(CMD_WAIT, 8'h00, 1'b0, 1'b1);
        send_command(CMD_READ, 8'h00, 1'b1, 1'b0);
        send_command(CMD_START, 8'h00, 1'b0, 1'b0);
        send_command(CMD_STOP, 8'h00, 1'b0, 1'b0);
        settle();

        // Longest half period: only the first ticks of a stop, finished after the next write.
        write_reg(CFG_HALF, 16'hFFFF);
        write_reg(CFG_ACK_TO, 16'd255);
        add_tick(CMD_STOP, 1'b1);
        fill_ticks(3, 1'b1, 1'b0);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            if (ph == 0) begin
                write_reg(CFG_HALF, 16'd1);
                write_reg(CFG_ACK_TO, 16'd4);
            end else begin
                write_reg(CFG_HALF, 16'($urandom_range(2)));
                write_reg(CFG_ACK_TO, 16'($urandom_range(6)));
            end
            phase_base = items_sent;
            // Lets an unfinished command from the previous setting run out first.
            fill_ticks(4, 1'b0, 1'b0);
            while (items_sent - phase_base < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    repeat ($urandom_range(3, 1)) add_tick(idle_kind(), 1'($urandom_range(1)));
                end else if (pick < 16) begin
                    // Acknowledge wait with a random SDA line: outcome left to chance.
                    add_tick(CMD_WAIT, 1'($urandom_range(1)));
                    fill_ticks(4 * ((cfg_half == 16'd0) ? 1 : int'(cfg_half))
                               + int'(cfg_timeout) + 2, 1'b0, 1'b0);
                end else if (pick < 30) begin
                    send_command(3'($urandom_range(5, 1)), 8'($urandom_range(255)),
                                 1'($urandom_range(1)), $urandom_range(1));
                end else begin
                    send_transaction();
                end
            end
            settle();
        end

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/i2cm_pkg.sv
sv/i2cm_front.sv
sv/i2cm_engine.sv
sv/i2c_master_bit_engine.sv
tb/sv/tb.sv
